// ===== hdl/nmfd_pkg.sv =====
// Shared types and constants for the NCO mixer, FIR and decimator.
package nmfd_pkg;

    localparam int TAP_COUNT = 64;

    typedef enum logic [1:0] {
        OP_MIX1,
        OP_MIX2,
        OP_FIR
    } mac_op_t;

    typedef struct packed {
        logic    load_in;
        logic    nco;
        logic    mac;
        mac_op_t mac_op;
        logic    first;
        logic    rnd;
        logic    rnd_fir;
        logic    dl_write;
        logic    out_load;
        logic    out_bypass;
    } dp_cmd_t;

    typedef struct packed {
        logic bypass;
        logic fire;
        logic busy;
        logic out_free;
    } dp_status_t;

    localparam logic [1:0] REG_PHASE_INC  = 2'd0;
    localparam logic [1:0] REG_DECIMATION = 2'd1;
    localparam logic [1:0] REG_OUT_SHIFT  = 2'd2;

    localparam logic [31:0] RST_PHASE_INC  = 32'd0;
    localparam logic [9:0]  RST_DECIMATION = 10'd1;
    localparam logic [5:0]  RST_OUT_SHIFT  = 6'd17;

endpackage

// ===== hdl/nco_mix_fir_decimator.sv =====
// Top level: register port, controller and datapath of the down-converter.
// Tap write: stored on acceptance, with no busy period. Bypass sample (decimation 0 or 1): input copied to the output.
// Mixed sample without output: NCO lookup, two MAC passes, round, write to the delay line.
// Mixed sample with output: the same, then all 64 taps, one tap per cycle through the MAC lanes, round and output.
// One transaction at a time; the output register lets the next one start while a result waits.
// rst_n clears control, NCO phase, counters and tap valid bits; registers take their defaults.
module nco_mix_fir_decimator #(
    parameter int SAMPLE_BITS    = 16,
    parameter int COEFF_BITS     = 18,
    parameter int NCO_TABLE_BITS = 10
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [3:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           action,
    input  logic signed [SAMPLE_BITS-1:0]  sample_i,
    input  logic signed [SAMPLE_BITS-1:0]  sample_q,
    input  logic [5:0]                     tap_index,
    input  logic signed [COEFF_BITS-1:0]   tap_value,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [SAMPLE_BITS-1:0]  out_i,
    output logic signed [SAMPLE_BITS-1:0]  out_q
);
    import nmfd_pkg::*;

    logic [31:0] phase_inc_reg;
    logic [9:0]  decimation_reg;
    logic [5:0]  out_shift_reg;
    logic        cfg_wr;
    dp_cmd_t     cmd;
    dp_status_t  status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_inc_reg  <= RST_PHASE_INC;
            decimation_reg <= RST_DECIMATION;
            out_shift_reg  <= RST_OUT_SHIFT;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_PHASE_INC:  phase_inc_reg  <= pwdata;
                REG_DECIMATION: decimation_reg <= pwdata[9:0];
                REG_OUT_SHIFT:  out_shift_reg  <= pwdata[5:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_PHASE_INC:  prdata = phase_inc_reg;
            REG_DECIMATION: prdata = {22'd0, decimation_reg};
            REG_OUT_SHIFT:  prdata = {26'd0, out_shift_reg};
            default:        prdata = '0;
        endcase
    end

    nmfd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .action   (action),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    nmfd_datapath #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEFF_BITS     (COEFF_BITS),
        .NCO_TABLE_BITS (NCO_TABLE_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .action          (action),
        .sample_i        (sample_i),
        .sample_q        (sample_q),
        .tap_index       (tap_index),
        .tap_value       (tap_value),
        .phase_increment (phase_inc_reg),
        .decimation      (decimation_reg),
        .output_shift    (out_shift_reg),
        .cmd             (cmd),
        .status          (status),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .out_i           (out_i),
        .out_q           (out_q)
    );

endmodule

// ===== hdl/nmfd_ctrl.sv =====
// Sequencing state machine for the down-converter datapath.
module nmfd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                action,
    output logic                in_stall,
    input  nmfd_pkg::dp_status_t status,
    output nmfd_pkg::dp_cmd_t    cmd
);
    import nmfd_pkg::*;

    localparam int AW = $clog2(TAP_COUNT);

    typedef enum logic [3:0] {
        S_IDLE,
        S_BYPASS,
        S_NCO,
        S_MIX1,
        S_MIX2,
        S_MIX_DRAIN,
        S_MIX_RND,
        S_WRITE,
        S_CHECK,
        S_FIR,
        S_FIR_DRAIN,
        S_FIR_RND,
        S_OUT
    } state_t;

    state_t          state_reg, state_next;
    logic [AW-1:0]   k_reg, k_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        cmd        = '0;
        cmd.mac_op = OP_MIX1;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load_in = in_valid;
                if (in_valid && !action)
                begin
                    state_next = status.bypass ? S_BYPASS : S_NCO;
                end
            end
            S_BYPASS:
            begin
                if (status.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_bypass = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_NCO:
            begin
                cmd.nco    = 1'b1;
                state_next = S_MIX1;
            end
            S_MIX1:
            begin
                cmd.mac    = 1'b1;
                cmd.mac_op = OP_MIX1;
                cmd.first  = 1'b1;
                state_next = S_MIX2;
            end
            S_MIX2:
            begin
                cmd.mac    = 1'b1;
                cmd.mac_op = OP_MIX2;
                state_next = S_MIX_DRAIN;
            end
            S_MIX_DRAIN:
            begin
                if (!status.busy)
                begin
                    state_next = S_MIX_RND;
                end
            end
            S_MIX_RND:
            begin
                cmd.rnd    = 1'b1;
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                cmd.dl_write = 1'b1;
                state_next   = S_CHECK;
            end
            S_CHECK:
            begin
                k_next     = '0;
                state_next = status.fire ? S_FIR : S_IDLE;
            end
            S_FIR:
            begin
                cmd.mac    = 1'b1;
                cmd.mac_op = OP_FIR;
                cmd.first  = (k_reg == '0);
                k_next     = k_reg + AW'(1);
                if (k_reg == AW'(TAP_COUNT - 1))
                begin
                    state_next = S_FIR_DRAIN;
                end
            end
            S_FIR_DRAIN:
            begin
                if (!status.busy)
                begin
                    state_next = S_FIR_RND;
                end
            end
            S_FIR_RND:
            begin
                cmd.rnd     = 1'b1;
                cmd.rnd_fir = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

endmodule

// ===== hdl/nmfd_datapath.sv =====
// NCO, complex MAC lanes, delay line and tap memories, rounding and output register.
module nmfd_datapath #(
    parameter int SAMPLE_BITS    = 16,
    parameter int COEFF_BITS     = 18,
    parameter int NCO_TABLE_BITS = 10
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           action,
    input  logic signed [SAMPLE_BITS-1:0]  sample_i,
    input  logic signed [SAMPLE_BITS-1:0]  sample_q,
    input  logic [5:0]                     tap_index,
    input  logic signed [COEFF_BITS-1:0]   tap_value,
    input  logic [31:0]                    phase_increment,
    input  logic [9:0]                     decimation,
    input  logic [5:0]                     output_shift,
    input  nmfd_pkg::dp_cmd_t              cmd,
    output nmfd_pkg::dp_status_t           status,
    input  logic                           out_stall,
    output logic                           out_valid,
    output logic signed [SAMPLE_BITS-1:0]  out_i,
    output logic signed [SAMPLE_BITS-1:0]  out_q
);
    import nmfd_pkg::*;

    localparam int SB   = SAMPLE_BITS;
    localparam int TB   = NCO_TABLE_BITS;
    localparam int AW   = $clog2(TAP_COUNT);
    localparam int FW   = $clog2(TAP_COUNT + 1);
    localparam int BW   = (COEFF_BITS > 16) ? COEFF_BITS : 16;
    localparam int PW   = SB + BW;
    localparam int ACCW = PW + AW + 1;
    localparam int QN   = 1 << (TB - 2);
    localparam int KW   = TB - 1;

    typedef logic signed [15:0] qtab_t [0:QN];

    function automatic qtab_t build_qtab();
        qtab_t  tab;
        longint z;
        longint z2;
        longint t;
        for (int k = 0; k <= QN; k++)
        begin
            z  = longint'(k) <<< (32 - TB);
            z2 = (z * z) >>> 30;
            t  = 172272;
            t  = -5026995 + ((t * z2) >>> 30);
            t  = 85569306 + ((t * z2) >>> 30);
            t  = -693598670 + ((t * z2) >>> 30);
            t  = 1686629713 + ((t * z2) >>> 30);
            t  = (t * z) >>> 30;
            t  = (t + 16384) >>> 15;
            if (t > 32767)
            begin
                t = 32767;
            end
            tab[k] = 16'(t);
        end
        return tab;
    endfunction

    localparam qtab_t QSIN = build_qtab();

    function automatic logic signed [15:0] nco_lookup(input logic [TB-1:0] p);
        logic [1:0]         quad;
        logic [KW-1:0]      ks;
        logic signed [15:0] v;
        quad = p[TB-1 -: 2];
        ks   = quad[0] ? (KW'(QN) - KW'(p[TB-3:0])) : KW'(p[TB-3:0]);
        v    = QSIN[ks];
        return quad[1] ? -v : v;
    endfunction

    function automatic logic signed [SB-1:0] sat(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (SB - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi)
        begin
            return SB'(hi);
        end
        if (v < lo)
        begin
            return SB'(lo);
        end
        return SB'(v);
    endfunction

    // input capture, NCO
    logic signed [SB-1:0]  x_reg, y_reg;
    logic [31:0]           phase_reg;
    logic signed [15:0]    sin_reg, cos_reg;
    logic [TB-1:0]         ph_top;

    // memories
    logic signed [SB-1:0]         dl_i_mem [0:TAP_COUNT-1];
    logic signed [SB-1:0]         dl_q_mem [0:TAP_COUNT-1];
    logic signed [COEFF_BITS-1:0] tap_mem  [0:TAP_COUNT-1];
    logic [TAP_COUNT-1:0]         tap_vld_reg;
    logic signed [SB-1:0]         dl_i_rd_reg, dl_q_rd_reg;
    logic signed [COEFF_BITS-1:0] tap_rd_reg;
    logic                         tap_ok_reg;
    logic [AW-1:0]                wptr_reg, rd_ptr_reg, tap_ptr_reg;
    logic [AW-1:0]                rd_addr, tap_addr;
    logic [FW-1:0]                fill_reg, fill_after;
    logic [9:0]                   dphase_reg;
    logic [10:0]                  dphase_inc;
    logic                         fire_reg;
    logic                         tap_wr;

    // MAC pipeline
    logic                   s1_valid_reg, s1_clr_reg, s1_neg_reg;
    mac_op_t                s1_op_reg;
    logic                   s2_valid_reg, s2_clr_reg, s2_neg_reg;
    logic signed [SB-1:0]   a_i, a_q;
    logic signed [BW-1:0]   b_i, b_q, b_tap;
    logic signed [PW-1:0]   prod_i_reg, prod_q_reg;
    logic signed [ACCW-1:0] add_i, add_q;
    logic signed [ACCW-1:0] acc_i_reg, acc_q_reg;

    // rounding and output
    logic [5:0]             sh;
    logic signed [63:0]     half;
    logic signed [63:0]     rnd_i_reg, rnd_q_reg;
    logic                   out_valid_reg;
    logic signed [SB-1:0]   out_i_reg, out_q_reg;

    assign ph_top = phase_reg[31 -: TB];
    assign tap_wr = cmd.load_in && action && (32'(tap_index) < 32'(TAP_COUNT));

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            x_reg <= sample_i;
            y_reg <= sample_q;
        end
        if (cmd.nco)
        begin
            sin_reg <= nco_lookup(ph_top);
            cos_reg <= nco_lookup(ph_top + TB'(QN));
        end
    end

    assign rd_addr  = cmd.first ? wptr_reg : rd_ptr_reg;
    assign tap_addr = cmd.first ? '0 : tap_ptr_reg;

    always_ff @(posedge clk)
    begin
        if (tap_wr)
        begin
            tap_mem[AW'(tap_index)] <= tap_value;
        end
        if (cmd.dl_write)
        begin
            dl_i_mem[wptr_reg] <= sat(rnd_i_reg);
            dl_q_mem[wptr_reg] <= sat(rnd_q_reg);
        end
        dl_i_rd_reg <= dl_i_mem[rd_addr];
        dl_q_rd_reg <= dl_q_mem[rd_addr];
        tap_rd_reg  <= tap_mem[tap_addr];
        tap_ok_reg  <= tap_vld_reg[tap_addr];
    end

    assign fill_after = (fill_reg == FW'(TAP_COUNT)) ? fill_reg : (fill_reg + FW'(1));
    assign dphase_inc = {1'b0, dphase_reg} + 11'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= '0;
            tap_vld_reg <= '0;
            wptr_reg    <= '0;
            rd_ptr_reg  <= '0;
            tap_ptr_reg <= '0;
            fill_reg    <= '0;
            dphase_reg  <= '0;
            fire_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.nco)
            begin
                phase_reg <= phase_reg + phase_increment;
            end
            if (tap_wr)
            begin
                tap_vld_reg[AW'(tap_index)] <= 1'b1;
            end
            if (cmd.mac && (cmd.mac_op == OP_FIR))
            begin
                rd_ptr_reg  <= (rd_addr == AW'(TAP_COUNT - 1)) ? '0 : (rd_addr + AW'(1));
                tap_ptr_reg <= tap_addr + AW'(1);
            end
            if (cmd.dl_write)
            begin
                wptr_reg <= (wptr_reg == AW'(TAP_COUNT - 1)) ? '0 : (wptr_reg + AW'(1));
                fill_reg <= fill_after;
                fire_reg <= 1'b0;
                if (fill_after == FW'(TAP_COUNT))
                begin
                    fire_reg   <= (dphase_reg == '0);
                    dphase_reg <= (dphase_inc >= {1'b0, decimation}) ? '0 : dphase_inc[9:0];
                end
            end
        end
    end

    assign b_tap = tap_ok_reg ? BW'(tap_rd_reg) : '0;

    always_comb
    begin
        unique case (s1_op_reg)
            OP_MIX1:
            begin
                a_i = x_reg;
                b_i = BW'(cos_reg);
                a_q = x_reg;
                b_q = BW'(sin_reg);
            end
            OP_MIX2:
            begin
                a_i = y_reg;
                b_i = BW'(sin_reg);
                a_q = y_reg;
                b_q = BW'(cos_reg);
            end
            OP_FIR:
            begin
                a_i = dl_i_rd_reg;
                b_i = b_tap;
                a_q = dl_q_rd_reg;
                b_q = b_tap;
            end
            default:
            begin
                a_i = '0;
                b_i = '0;
                a_q = '0;
                b_q = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.mac;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    assign add_i = s2_neg_reg ? -ACCW'(prod_i_reg) : ACCW'(prod_i_reg);
    assign add_q = ACCW'(prod_q_reg);

    always_ff @(posedge clk)
    begin
        s1_op_reg  <= cmd.mac_op;
        s1_clr_reg <= cmd.first;
        s1_neg_reg <= (cmd.mac_op == OP_MIX2);
        s2_clr_reg <= s1_clr_reg;
        s2_neg_reg <= s1_neg_reg;
        prod_i_reg <= a_i * b_i;
        prod_q_reg <= a_q * b_q;
        if (s2_valid_reg)
        begin
            acc_i_reg <= s2_clr_reg ? add_i : (acc_i_reg + add_i);
            acc_q_reg <= s2_clr_reg ? add_q : (acc_q_reg + add_q);
        end
    end

    assign sh   = cmd.rnd_fir ? output_shift : 6'd15;
    assign half = (sh == 6'd0) ? 64'sd0 : (64'sd1 <<< (sh - 6'd1));

    always_ff @(posedge clk)
    begin
        if (cmd.rnd)
        begin
            rnd_i_reg <= (64'(acc_i_reg) + half) >>> sh;
            rnd_q_reg <= (64'(acc_q_reg) + half) >>> sh;
        end
        if (cmd.out_load)
        begin
            out_i_reg <= cmd.out_bypass ? x_reg : sat(rnd_i_reg);
            out_q_reg <= cmd.out_bypass ? y_reg : sat(rnd_q_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_i           = out_i_reg;
    assign out_q           = out_q_reg;
    assign status.bypass   = (decimation <= 10'd1);
    assign status.fire     = fire_reg;
    assign status.busy     = s1_valid_reg || s2_valid_reg;
    assign status.out_free = !out_valid_reg || !out_stall;

endmodule

// ===== hdl/nmfd_checker.sv =====
// Port-level checks for the down-converter, bound to the top level.
module nmfd_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_stall,
    input logic                   action,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic [SAMPLE_BITS-1:0] out_i,
    input logic [SAMPLE_BITS-1:0] out_q,
    input logic                   pready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_i) && $stable(out_q))
        else $error("output transaction changed while stalled");

    a_tap_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && action |=> !in_stall)
        else $error("tap write did not complete in one cycle");

    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !action |=> in_stall)
        else $error("sample transaction accepted without busy period");

    a_pready: assert property (@(posedge clk) pready)
        else $error("pready low");

endmodule

bind nco_mix_fir_decimator nmfd_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_nmfd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_i     (out_i),
    .out_q     (out_q),
    .pready    (pready)
);

// ===== bench/nmfd_checker.sv =====
// Checker: watches the sample and result channels, predicts the down-converter and compares.
module nmfd_scoreboard (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_idx,
    input  logic [31:0]        cfg_val,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               action,
    input  logic signed [15:0] sample_i,
    input  logic signed [15:0] sample_q,
    input  logic [5:0]         tap_index,
    input  logic signed [17:0] tap_value,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [15:0] out_i,
    input  logic signed [15:0] out_q,
    output int                 fail_count,
    output int                 pending,
    output int                 results_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import nmfd_pkg::*;

    typedef struct packed {
        logic signed [15:0] i;
        logic signed [15:0] q;
    } iq_t;

    iq_t                 expected_iq[$];
    logic [31:0]         m_inc;
    logic [9:0]          m_dec;
    logic [5:0]          m_shift;
    logic [31:0]         m_phase;
    logic signed [63:0]  m_dl_i[64];
    logic signed [63:0]  m_dl_q[64];
    logic signed [63:0]  m_taps[64];
    logic [9:0]          m_dec_phase;
    int                  m_fill;

    function automatic logic signed [63:0] sat16(input logic signed [63:0] v);
        if (v > 64'sd32767) return 64'sd32767;
        if (v < -64'sd32768) return -64'sd32768;
        return v;
    endfunction

    function automatic logic signed [63:0] quarter_sin(input logic signed [63:0] z);
        logic signed [63:0] z2, t;
        z2 = (z * z) >>> 30;
        t = 64'sd172272;
        t = -64'sd5026995 + ((t * z2) >>> 30);
        t = 64'sd85569306 + ((t * z2) >>> 30);
        t = -64'sd693598670 + ((t * z2) >>> 30);
        t = 64'sd1686629713 + ((t * z2) >>> 30);
        t = (t * z) >>> 30;
        t = (t + 64'sd16384) >>> 15;
        return (t > 64'sd32767) ? 64'sd32767 : t;
    endfunction

    function automatic logic signed [63:0] nco_sin(input logic [31:0] u);
        logic signed [63:0] r, v;
        r = {34'd0, u[29:0]};
        v = quarter_sin(u[30] ? (64'sd1073741824 - r) : r);
        return u[31] ? -v : v;
    endfunction

    task automatic predict_sample(input logic signed [15:0] xi, input logic signed [15:0] yq);
        logic [31:0]        u;
        logic signed [63:0] s, c, x, y, re, im, ai, aq, half;
        iq_t                r;
        x = 64'(xi);
        y = 64'(yq);
        if (m_dec <= 10'd1) begin
            r.i = xi;
            r.q = yq;
            expected_iq.push_back(r);
            return;
        end
        u = {m_phase[31:22], 22'd0};
        s = nco_sin(u);
        c = nco_sin(u + 32'h4000_0000);
        m_phase = m_phase + m_inc;
        re = sat16((x * c - y * s + 64'sd16384) >>> 15);
        im = sat16((x * s + y * c + 64'sd16384) >>> 15);
        for (int k = 0; k < 63; k++) begin
            m_dl_i[k] = m_dl_i[k+1];
            m_dl_q[k] = m_dl_q[k+1];
        end
        m_dl_i[63] = re;
        m_dl_q[63] = im;
        if (m_fill < 64) m_fill++;
        if (m_fill < 64) return;
        if (m_dec_phase != 0) begin
            m_dec_phase = (m_dec_phase + 1 >= m_dec) ? 10'd0 : m_dec_phase + 10'd1;
            return;
        end
        m_dec_phase = (m_dec <= 10'd1) ? 10'd0 : 10'd1;
        ai = '0;
        aq = '0;
        for (int k = 0; k < 64; k++) begin
            ai += m_dl_i[k] * m_taps[k];
            aq += m_dl_q[k] * m_taps[k];
        end
        half = (m_shift != 0) ? (64'sd1 <<< (m_shift - 6'd1)) : 64'sd0;
        r.i = 16'(sat16((ai + half) >>> m_shift));
        r.q = 16'(sat16((aq + half) >>> m_shift));
        expected_iq.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_inc = RST_PHASE_INC;
            m_dec = RST_DECIMATION;
            m_shift = RST_OUT_SHIFT;
            m_phase = '0;
            m_dec_phase = '0;
            m_fill = 0;
            for (int k = 0; k < 64; k++) begin
                m_dl_i[k] = '0;
                m_dl_q[k] = '0;
                m_taps[k] = '0;
            end
            expected_iq.delete();
            fail_count = 0;
            results_seen = 0;
            pending = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_idx)
                    REG_PHASE_INC:  m_inc = cfg_val;
                    REG_DECIMATION: m_dec = cfg_val[9:0];
                    REG_OUT_SHIFT:  m_shift = cfg_val[5:0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall) begin
                results_seen++;
                if (expected_iq.size() == 0) begin
                    $error("unexpected result out_i=%0d out_q=%0d", out_i, out_q);
                    fail_count++;
                end else begin
                    iq_t e;
                    e = expected_iq.pop_front();
                    if (out_i !== e.i) begin
                        $error("out_i expected %0d actual %0d", e.i, out_i);
                        fail_count++;
                    end
                    if (out_q !== e.q) begin
                        $error("out_q expected %0d actual %0d", e.q, out_q);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall) begin
                if (action)
                    m_taps[tap_index] = 64'(tap_value);
                else
                    predict_sample(sample_i, sample_q);
            end
            pending = expected_iq.size();
        end
    end
endmodule

// ===== bench/testbench.sv =====
// Testbench top: drives samples, tap writes and register writes, and gives the verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import nmfd_pkg::*;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               psel = 0, penable = 0, pwrite = 0;
    logic [3:0]         paddr = 0;
    logic [31:0]        pwdata = 0;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid = 0;
    logic               in_stall;
    logic               action = 0;
    logic signed [15:0] sample_i = 0, sample_q = 0;
    logic [5:0]         tap_index = 0;
    logic signed [17:0] tap_value = 0;
    logic               out_valid;
    logic               out_stall = 0;
    logic signed [15:0] out_i, out_q;
    int                 fail_count, pending, results_seen;
    int                 idle_cycles = 0;
    int                 sent = 0;
    bit                 src_gaps = 1, sink_gaps = 1, hold_sink = 0;

    always begin
        #6 clk = 1;
        #6 clk = 0;
    end

    nco_mix_fir_decimator i_dut (.*);

    nmfd_scoreboard i_chk (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(psel && penable && pwrite && pready), .cfg_idx(paddr[3:2]), .cfg_val(pwdata),
        .in_valid(in_valid), .in_stall(in_stall), .action(action),
        .sample_i(sample_i), .sample_q(sample_q), .tap_index(tap_index), .tap_value(tap_value),
        .out_valid(out_valid), .out_stall(out_stall), .out_i(out_i), .out_q(out_q),
        .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
    );

    // receiver stalls: random bursts, or one long hold-off
    initial begin
        int n;
        forever begin
            @(posedge clk);
            if (hold_sink) begin
                out_stall <= 1;
                repeat (400) @(posedge clk);
                hold_sink = 0;
                out_stall <= 0;
            end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 15);
                out_stall <= 1;
                repeat (n - 1) @(posedge clk);
                out_stall <= 0;
            end else
                out_stall <= 0;
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("[nco_mix_fir_decimator] ERROR");
            $finish;
        end
    end

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic send(input logic act, input logic [15:0] si, input logic [15:0] sq,
                        input logic [5:0] ti, input logic [17:0] tv);
        int n;
        if (src_gaps && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 15);
            in_valid <= 0;
            repeat (n) @(posedge clk);
        end
        in_valid <= 1; action <= act; sample_i <= si; sample_q <= sq;
        tap_index <= ti; tap_value <= tv;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent++;
    endtask

    task automatic drain;
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic load_taps(input bit rnd);
        for (int k = 0; k < 64; k++)
            send(1'b1, 16'($urandom), 16'($urandom), 6'(k),
                 rnd ? 18'($urandom) : ((k == 63) ? 18'sd65536 : 18'sd2000));
    endtask

    task automatic samples(input int n);
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 9);
            if (r == 0)
                send(1'b1, 16'($urandom), 16'($urandom), 6'($urandom), 18'($urandom));
            else if (r == 1)
                send(1'b0, $urandom_range(0, 1) ? 16'h7fff : 16'h8000,
                     $urandom_range(0, 1) ? 16'h7fff : 16'h8000,
                     6'($urandom), 18'($urandom));
            else
                send(1'b0, 16'($urandom), 16'($urandom), 6'($urandom), 18'($urandom));
        end
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // bypass at reset settings, field extremes
        send(1'b0, 16'h7fff, 16'h8000, '0, '0);
        send(1'b0, 16'h8000, 16'h7fff, '0, '0);
        send(1'b0, '0, '0, '0, '0);
        send(1'b1, '0, '0, 6'd63, 18'h1ffff);
        send(1'b1, '0, '0, 6'd0, 18'h20000);
        drain();
        reg_write(REG_DECIMATION, 32'd0);
        send(1'b0, 16'h1234, 16'hfedc, '0, '0);
        drain();
        reg_write(REG_DECIMATION, 32'd2);
        reg_write(REG_PHASE_INC, 32'h7fff_ffff);
        reg_write(REG_OUT_SHIFT, 32'd0);
        load_taps(0);
        samples(80);
        drain();
        reg_write(REG_OUT_SHIFT, 32'd40);
        reg_write(REG_PHASE_INC, 32'h8000_0000);
        reg_write(REG_DECIMATION, 32'd1000);
        samples(30);
        drain();
        reg_write(REG_DECIMATION, 32'd3);
        reg_write(REG_OUT_SHIFT, 32'd63);
        samples(20);
        drain();
        // long receiver hold-off while the sender keeps going
        reg_write(REG_DECIMATION, 32'd2);
        reg_write(REG_OUT_SHIFT, 32'd17);
        reg_write(REG_PHASE_INC, $urandom);
        hold_sink = 1;
        samples(60);
        drain();
        for (int ph = 0; ph < 4; ph++) begin
            reg_write(REG_PHASE_INC, $urandom);
            reg_write(REG_DECIMATION, $urandom_range(2, 5));
            reg_write(REG_OUT_SHIFT, $urandom_range(10, 22));
            if (ph == 1) load_taps(1);
            if (ph == 3) begin
                src_gaps = 0;
                sink_gaps = 0;
            end
            samples(75);
            drain();
        end
        reg_write(REG_DECIMATION, 32'd1);
        samples(40);
        drain();
        $display("covered bypass, decimation 2..1000, shifts 0..63, %0d items, %0d results",
                 sent, results_seen);
        if (fail_count == 0)
            $display("[nco_mix_fir_decimator] OK");
        else
            $display("[nco_mix_fir_decimator] ERROR");
        $finish;
    end
endmodule
